>>> hdl/ftvd_pkg.sv
// ---------------------------------------------------------------------------
// ftvd_pkg: shared types and constants
// widths, hash constants and the link between the sequencer and the table
// ---------------------------------------------------------------------------
package ftvd_pkg;

   // table geometry, slot count must be a power of two
   localparam int TABLE_SLOTS = 16384;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);

   // field widths
   localparam int KEY_W  = 32;
   localparam int VTX_W  = 14;
   localparam int VCNT_W = 15;

   // number of vertex numbers that can be handed out
   localparam logic [VCNT_W-1:0] VTX_LIMIT = VCNT_W'(16384);

   // hash multipliers
   localparam logic [KEY_W-1:0] HASH_K_POS = 32'd73856093;
   localparam logic [KEY_W-1:0] HASH_K_TEX = 32'd19349663;
   localparam logic [KEY_W-1:0] HASH_K_NRM = 32'd83492791;

   // one table slot
   typedef struct packed {
      logic             used;
      logic [KEY_W-1:0] pos;
      logic [KEY_W-1:0] tex;
      logic [KEY_W-1:0] nrm;
      logic [VTX_W-1:0] vertex;
   } slot_entry_type;

   // lookup request from the sequencer
   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] pos;
      logic [KEY_W-1:0] tex;
      logic [KEY_W-1:0] nrm;
   } lookup_req_type;

   // lookup status and result back to the sequencer
   typedef struct packed {
      logic             ready;
      logic             done;
      logic [VTX_W-1:0] vertex;
      logic             is_new;
      logic             full;
   } lookup_rsp_type;

endpackage

>>> hdl/ftvd_if.sv
// ---------------------------------------------------------------------------
// ftvd_if: corner and vertex stream interfaces
// valid/ready channels carrying face corners in and triangle vertices out
// ---------------------------------------------------------------------------
interface ftvd_req_if;
   import ftvd_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] pos_index;
   logic [KEY_W-1:0] tex_index;
   logic [KEY_W-1:0] nrm_index;
   logic             last_corner;

   modport source (output valid, output pos_index, output tex_index, output nrm_index,
                   output last_corner, input ready);
   modport sink   (input valid, input pos_index, input tex_index, input nrm_index,
                   input last_corner, output ready);
endinterface

interface ftvd_rsp_if;
   import ftvd_pkg::*;

   logic             valid;
   logic             ready;
   logic [VTX_W-1:0] vertex_index;
   logic             is_new;
   logic [KEY_W-1:0] out_pos;
   logic [KEY_W-1:0] out_tex;
   logic [KEY_W-1:0] out_nrm;
   logic             table_full;
   logic             last;

   modport source (output valid, output vertex_index, output is_new, output out_pos,
                   output out_tex, output out_nrm, output table_full, output last,
                   input ready);
   modport sink   (input valid, input vertex_index, input is_new, input out_pos,
                   input out_tex, input out_nrm, input table_full, input last,
                   output ready);
endinterface

>>> hdl/fan_triangulate_vertex_dedup.sv
// ---------------------------------------------------------------------------
// fan_triangulate_vertex_dedup: fan triangulation with vertex deduplication
// holds the first two corners of a face and emits one fan triangle per later
// corner, each vertex looked up or inserted in a linear-probing hash table
// ---------------------------------------------------------------------------
// corners that start a face are only held; a corner that emits a triangle
// runs three serial table lookups, each hashing its key on one multiplier
// and then reading memory once per probe step
// vertex beats follow the corner beat, one beat per lookup
// reset is synchronous; afterwards the table is cleared one slot a cycle,
// during which no corner beat is taken
module fan_triangulate_vertex_dedup (
   input logic         clock,
   input logic         reset,
   ftvd_req_if.sink    req_if,
   ftvd_rsp_if.source  rsp_if
);
   import ftvd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   localparam logic [1:0] SEL_FIRST  = 2'd0;
   localparam logic [1:0] SEL_SECOND = 2'd1;
   localparam logic [1:0] SEL_CUR    = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       corner_cnt_ff, corner_cnt_in;
   logic [1:0]       sel_ff, sel_in;
   logic             face_end_ff, face_end_in;
   logic [KEY_W-1:0] first_pos_ff, first_pos_in;
   logic [KEY_W-1:0] first_tex_ff, first_tex_in;
   logic [KEY_W-1:0] first_nrm_ff, first_nrm_in;
   logic [KEY_W-1:0] second_pos_ff, second_pos_in;
   logic [KEY_W-1:0] second_tex_ff, second_tex_in;
   logic [KEY_W-1:0] second_nrm_ff, second_nrm_in;
   logic [KEY_W-1:0] cur_pos_ff, cur_pos_in;
   logic [KEY_W-1:0] cur_tex_ff, cur_tex_in;
   logic [KEY_W-1:0] cur_nrm_ff, cur_nrm_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic             rsp_new_ff, rsp_new_in;
   logic [KEY_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [KEY_W-1:0] rsp_tex_ff, rsp_tex_in;
   logic [KEY_W-1:0] rsp_nrm_ff, rsp_nrm_in;
   logic             rsp_full_ff, rsp_full_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             out_free;
   logic             out_load;
   logic [KEY_W-1:0] sel_pos;
   logic [KEY_W-1:0] sel_tex;
   logic [KEY_W-1:0] sel_nrm;
   lookup_req_type   lk_req;
   lookup_rsp_type   lk_rsp;

   // table lookup unit
   ftvd_probe u_probe (
      .clock  (clock),
      .reset  (reset),
      .lk_req (lk_req),
      .lk_rsp (lk_rsp)
   );

   // handshakes
   assign req_if.ready = (state_ff == S_IDLE) && lk_rsp.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign out_load     = (state_ff == S_EMIT) && out_free;

   // triangle corner select
   always_comb begin
      case (sel_ff)
         SEL_FIRST: begin
            sel_pos = first_pos_ff;
            sel_tex = first_tex_ff;
            sel_nrm = first_nrm_ff;
         end
         SEL_SECOND: begin
            sel_pos = second_pos_ff;
            sel_tex = second_tex_ff;
            sel_nrm = second_nrm_ff;
         end
         default: begin
            sel_pos = cur_pos_ff;
            sel_tex = cur_tex_ff;
            sel_nrm = cur_nrm_ff;
         end
      endcase
   end

   always_comb begin
      lk_req.start = (state_ff == S_START);
      lk_req.pos   = sel_pos;
      lk_req.tex   = sel_tex;
      lk_req.nrm   = sel_nrm;
   end

   // corner holding and triangle sequencing
   always_comb begin
      state_in      = state_ff;
      corner_cnt_in = corner_cnt_ff;
      sel_in        = sel_ff;
      face_end_in   = face_end_ff;
      first_pos_in  = first_pos_ff;
      first_tex_in  = first_tex_ff;
      first_nrm_in  = first_nrm_ff;
      second_pos_in = second_pos_ff;
      second_tex_in = second_tex_ff;
      second_nrm_in = second_nrm_ff;
      cur_pos_in    = cur_pos_ff;
      cur_tex_in    = cur_tex_ff;
      cur_nrm_in    = cur_nrm_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (corner_cnt_ff)
                  CNT_NONE: begin
                     first_pos_in  = req_if.pos_index;
                     first_tex_in  = req_if.tex_index;
                     first_nrm_in  = req_if.nrm_index;
                     corner_cnt_in = req_if.last_corner ? CNT_NONE : CNT_ONE;
                  end
                  CNT_ONE: begin
                     second_pos_in = req_if.pos_index;
                     second_tex_in = req_if.tex_index;
                     second_nrm_in = req_if.nrm_index;
                     corner_cnt_in = req_if.last_corner ? CNT_NONE : CNT_TWO;
                  end
                  CNT_TWO: begin
                     cur_pos_in  = req_if.pos_index;
                     cur_tex_in  = req_if.tex_index;
                     cur_nrm_in  = req_if.nrm_index;
                     face_end_in = req_if.last_corner;
                     sel_in      = SEL_FIRST;
                     state_in    = S_START;
                  end
                  default: begin
                     corner_cnt_in = CNT_NONE;
                  end
               endcase
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (lk_rsp.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               if (sel_ff == SEL_CUR) begin
                  // current corner becomes the previous one
                  second_pos_in = cur_pos_ff;
                  second_tex_in = cur_tex_ff;
                  second_nrm_in = cur_nrm_ff;
                  if (face_end_ff) begin
                     corner_cnt_in = CNT_NONE;
                  end
                  state_in = S_IDLE;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = S_START;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_tex_in    = rsp_tex_ff;
      rsp_nrm_in    = rsp_nrm_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = lk_rsp.vertex;
         rsp_new_in    = lk_rsp.is_new;
         rsp_pos_in    = sel_pos;
         rsp_tex_in    = sel_tex;
         rsp_nrm_in    = sel_nrm;
         rsp_full_in   = lk_rsp.full;
         rsp_last_in   = (sel_ff == SEL_CUR);
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         corner_cnt_ff <= CNT_NONE;
         sel_ff        <= SEL_FIRST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         corner_cnt_ff <= corner_cnt_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // held corners and output payload
   always_ff @(posedge clock) begin
      face_end_ff   <= face_end_in;
      first_pos_ff  <= first_pos_in;
      first_tex_ff  <= first_tex_in;
      first_nrm_ff  <= first_nrm_in;
      second_pos_ff <= second_pos_in;
      second_tex_ff <= second_tex_in;
      second_nrm_ff <= second_nrm_in;
      cur_pos_ff    <= cur_pos_in;
      cur_tex_ff    <= cur_tex_in;
      cur_nrm_ff    <= cur_nrm_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_tex_ff    <= rsp_tex_in;
      rsp_nrm_ff    <= rsp_nrm_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.vertex_index = rsp_vertex_ff;
   assign rsp_if.is_new       = rsp_new_ff;
   assign rsp_if.out_pos      = rsp_pos_ff;
   assign rsp_if.out_tex      = rsp_tex_ff;
   assign rsp_if.out_nrm      = rsp_nrm_ff;
   assign rsp_if.table_full   = rsp_full_ff;
   assign rsp_if.last         = rsp_last_ff;

`ifndef SYNTH
   // a triangle is only in flight with two corners held
   a_busy_two_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> corner_cnt_ff == CNT_TWO)
      else $error("triangle in flight without two held corners");

   // while waiting, the lookup unit is busy or has just finished
   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WAIT |-> (!lk_rsp.ready || lk_rsp.done))
      else $error("lookup unit idle without a result");

   // the third vertex beat closes the triangle
   a_last_beat: assert property (@(posedge clock) disable iff (reset)
      (out_load && sel_ff == SEL_CUR) |=> (rsp_if.valid && rsp_if.last
                                           && state_ff == S_IDLE))
      else $error("triangle not closed on third vertex beat");
`endif

endmodule

>>> hdl/ftvd_ram.sv
// ---------------------------------------------------------------------------
// ftvd_ram: generic single write, single read memory
// one write port and one read port, read data registered
// ---------------------------------------------------------------------------
module ftvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ftvd_probe.sv
// ---------------------------------------------------------------------------
// ftvd_probe: hash table lookup and insert
// hashes a key triple with one shared multiplier, then walks the table by
// linear probing, one slot per cycle; clears the table after reset
// ---------------------------------------------------------------------------
module ftvd_probe (
   input  logic                    clock,
   input  logic                    reset,
   input  ftvd_pkg::lookup_req_type lk_req,
   output ftvd_pkg::lookup_rsp_type lk_rsp
);
   import ftvd_pkg::*;

   localparam int ENTRY_W = $bits(slot_entry_type);

   localparam logic [2:0] P_CLEAR   = 3'd0;
   localparam logic [2:0] P_IDLE    = 3'd1;
   localparam logic [2:0] P_MUL_POS = 3'd2;
   localparam logic [2:0] P_MUL_TEX = 3'd3;
   localparam logic [2:0] P_MUL_NRM = 3'd4;
   localparam logic [2:0] P_ADDR    = 3'd5;
   localparam logic [2:0] P_PROBE   = 3'd6;

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [KEY_W-1:0]  key_pos_ff, key_pos_in;
   logic [KEY_W-1:0]  key_tex_ff, key_tex_in;
   logic [KEY_W-1:0]  key_nrm_ff, key_nrm_in;
   logic [KEY_W-1:0]  mult_ff, mult_in;
   logic [KEY_W-1:0]  acc_ff, acc_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] steps_ff, steps_in;
   logic [VCNT_W-1:0] vcnt_ff, vcnt_in;
   logic              done_ff, done_in;
   logic [VTX_W-1:0]  rs_vertex_ff, rs_vertex_in;
   logic              rs_new_ff, rs_new_in;
   logic              rs_full_ff, rs_full_in;

   logic [KEY_W-1:0]  mul_op;
   logic [KEY_W-1:0]  mul_k;
   logic [KEY_W-1:0]  prod;
   logic [KEY_W-1:0]  hash;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   slot_entry_type    entry;
   slot_entry_type    new_entry;
   logic              hit;
   logic              vtx_out;

   // slot storage
   ftvd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared hash multiplier, one key term per cycle
   always_comb begin
      unique case (state_ff)
         P_MUL_POS: begin
            mul_op = key_pos_ff;
            mul_k  = HASH_K_POS;
         end
         P_MUL_TEX: begin
            mul_op = key_tex_ff;
            mul_k  = HASH_K_TEX;
         end
         default: begin
            mul_op = key_nrm_ff;
            mul_k  = HASH_K_NRM;
         end
      endcase
   end

   assign prod = mul_op * mul_k;
   assign hash = acc_ff ^ mult_ff;

   // slot compare
   assign entry   = slot_entry_type'(rd_data);
   assign hit     = entry.used && (entry.pos == key_pos_ff) && (entry.tex == key_tex_ff)
                    && (entry.nrm == key_nrm_ff);
   assign vtx_out = (vcnt_ff >= VTX_LIMIT);

   always_comb begin
      new_entry.used   = 1'b1;
      new_entry.pos    = key_pos_ff;
      new_entry.tex    = key_tex_ff;
      new_entry.nrm    = key_nrm_ff;
      new_entry.vertex = vcnt_ff[VTX_W-1:0];
   end

   // control: clear sweep, hash, probe walk
   // a slot written in the probe state is read again no sooner than the next
   // lookup's address cycle, so no forwarding path is needed
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      key_pos_in   = key_pos_ff;
      key_tex_in   = key_tex_ff;
      key_nrm_in   = key_nrm_ff;
      mult_in      = mult_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      steps_in     = steps_ff;
      vcnt_in      = vcnt_ff;
      done_in      = 1'b0;
      rs_vertex_in = rs_vertex_ff;
      rs_new_in    = rs_new_ff;
      rs_full_in   = rs_full_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = slot_ff;

      unique case (state_ff)
         P_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = P_IDLE;
            end
         end
         P_IDLE: begin
            if (lk_req.start) begin
               key_pos_in = lk_req.pos;
               key_tex_in = lk_req.tex;
               key_nrm_in = lk_req.nrm;
               state_in   = P_MUL_POS;
            end
         end
         P_MUL_POS: begin
            mult_in  = prod;
            state_in = P_MUL_TEX;
         end
         P_MUL_TEX: begin
            acc_in   = mult_ff;
            mult_in  = prod;
            state_in = P_MUL_NRM;
         end
         P_MUL_NRM: begin
            acc_in   = acc_ff ^ mult_ff;
            mult_in  = prod;
            state_in = P_ADDR;
         end
         P_ADDR: begin
            slot_in  = hash[SLOT_W-1:0];
            steps_in = '0;
            rd_en    = 1'b1;
            rd_addr  = hash[SLOT_W-1:0];
            state_in = P_PROBE;
         end
         P_PROBE: begin
            if (!entry.used) begin
               // free slot: insert unless vertex numbers ran out
               done_in  = 1'b1;
               state_in = P_IDLE;
               if (vtx_out) begin
                  rs_vertex_in = '0;
                  rs_new_in    = 1'b0;
                  rs_full_in   = 1'b1;
               end else begin
                  wr_en        = 1'b1;
                  wr_data      = new_entry;
                  rs_vertex_in = vcnt_ff[VTX_W-1:0];
                  rs_new_in    = 1'b1;
                  rs_full_in   = 1'b0;
                  vcnt_in      = vcnt_ff + VCNT_W'(1);
               end
            end else if (hit) begin
               done_in      = 1'b1;
               state_in     = P_IDLE;
               rs_vertex_in = entry.vertex;
               rs_new_in    = 1'b0;
               rs_full_in   = 1'b0;
            end else if (steps_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               // walked the whole table
               done_in      = 1'b1;
               state_in     = P_IDLE;
               rs_vertex_in = '0;
               rs_new_in    = 1'b0;
               rs_full_in   = 1'b1;
            end else begin
               slot_in  = slot_ff + SLOT_W'(1);
               steps_in = steps_ff + SLOT_W'(1);
               rd_en    = 1'b1;
               rd_addr  = slot_ff + SLOT_W'(1);
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_CLEAR;
         clr_ff   <= '0;
         vcnt_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vcnt_ff  <= vcnt_in;
         done_ff  <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      key_pos_ff   <= key_pos_in;
      key_tex_ff   <= key_tex_in;
      key_nrm_ff   <= key_nrm_in;
      mult_ff      <= mult_in;
      acc_ff       <= acc_in;
      slot_ff      <= slot_in;
      steps_ff     <= steps_in;
      rs_vertex_ff <= rs_vertex_in;
      rs_new_ff    <= rs_new_in;
      rs_full_ff   <= rs_full_in;
   end

   // status and result
   always_comb begin
      lk_rsp.ready  = (state_ff == P_IDLE);
      lk_rsp.done   = done_ff;
      lk_rsp.vertex = rs_vertex_ff;
      lk_rsp.is_new = rs_new_ff;
      lk_rsp.full   = rs_full_ff;
   end

`ifndef SYNTH
   // a lookup is only started when the unit is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      lk_req.start |-> state_ff == P_IDLE)
      else $error("lookup started while probe unit busy");

   // a result is never both newly inserted and flagged full
   a_new_not_full: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !(rs_new_ff && rs_full_ff))
      else $error("result both new and full");

   // every insert takes exactly one vertex number
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == P_PROBE) |=> vcnt_ff == $past(vcnt_ff) + VCNT_W'(1))
      else $error("vertex count not advanced on insert");
`endif

endmodule
